>>> src/assert_macros.svh
// Assertion helpers for the distance pipeline; sampled on aclk, off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SD_ASSERT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("distance pipeline check failed");

// Next-cycle implication.
`define SD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("distance pipeline check failed");

`endif

>>> src/stdist_pkg.sv
package stdist_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int SQ_STEPS      = 32;        // one result bit per step of a 64-bit isqrt
    localparam int QW            = 34;        // quotient magnitude bits
    localparam int DIV_RW        = QW + 32;   // remainder width, holds divisor << (QW-1)

    typedef enum logic [2:0] {
        REG_MODE     = 3'd0,
        REG_SHIFT_X  = 3'd1,
        REG_SHIFT_Y  = 3'd2,
        REG_SHIFT_Z  = 3'd3,
        REG_LENGTHS  = 3'd4,
        REG_SCALES_A = 3'd5,
        REG_SCALES_B = 3'd6,
        REG_RADII    = 3'd7
    } reg_idx_t;

    // mode_flags bit positions
    localparam int MB_FOLD_X = 0;
    localparam int MB_FOLD_Y = 1;
    localparam int MB_FOLD_Z = 2;
    localparam int MB_SWAP   = 3;
    localparam int MB_ZX     = 4;
    localparam int MB_ZY     = 5;
    localparam int MB_YX     = 6;
    localparam int MB_XY     = 7;
    localparam int MB_SQUARE = 8;

    typedef struct packed {
        logic        [8:0]  mode;
        logic signed [31:0] shift_x;
        logic signed [31:0] shift_y;
        logic signed [31:0] shift_z;
        logic signed [31:0] len_x;
        logic signed [31:0] len_y;
        logic signed [31:0] sc_zx;
        logic signed [31:0] sc_zy;
        logic signed [31:0] sc_yx;
        logic signed [31:0] sc_xy;
        logic signed [31:0] ring_r;
        logic signed [31:0] thick;
    } cfg_t;

    // per-item data that rides along the pipeline
    typedef struct packed {
        logic signed [31:0] mx;
        logic signed [31:0] my;
        logic signed [31:0] mz;
        logic signed [31:0] prior;
        logic        [30:0] dsc;
        logic        [31:0] az;
    } carry_t;

endpackage

>>> src/stretched_torus_distance.sv
// Stretched torus distance estimator, one point per item.
//
// Input channel (s_*): point x/y/z, prior distance and derivative scale, all
// fixed point with FRAC_BITS fraction bits. Result channel (m_*): the shifted
// and folded point plus min(prior, scaled torus distance), saturated.
// Config port: cfg_wr_en/cfg_index/cfg_data, written one register per cycle
// while no item is in flight; the user must ensure this, the block does not.
//
// An item passes 109 register stages: 6 front stages (shift, stretch products,
// half-lengths, excess, squares, sum), two 32-step isqrt pipes, 3 glue stages
// between them, one thickness-subtract stage, a 34-step restoring divider and
// the output register. Throughput is one item per cycle while the receiver
// is not stalling the output.
//
// The whole pipe advances on one enable, taken low only when the output
// register holds a result the receiver has not taken; s_ready follows it, so
// a stall freezes every stage in place and nothing is dropped or repeated.
// Reset clears all valid bits and loads the register defaults: no shift, no
// stretch, half-length x of 1.0, ring radius 1.0, thickness 0.5.
`include "assert_macros.svh"

module stretched_torus_distance #(
    parameter int FRAC_BITS = stdist_pkg::FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_point_x,
    input  logic signed [31:0] s_point_y,
    input  logic signed [31:0] s_point_z,
    input  logic signed [31:0] s_prior_distance,
    input  logic        [30:0] s_derivative_scale,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_moved_x,
    output logic signed [31:0] m_moved_y,
    output logic signed [31:0] m_moved_z,
    output logic signed [31:0] m_new_distance
);

    localparam int CW  = $bits(stdist_pkg::carry_t);
    localparam int SW2 = CW + 32;          // carry plus |ring|
    localparam int SWD = CW + 1;           // carry plus quotient sign
    localparam int QW  = stdist_pkg::QW;
    localparam int RW  = stdist_pkg::DIV_RW;
    localparam int NS  = stdist_pkg::SQ_STEPS;

    // ---------------- configuration registers ----------------
    stdist_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode    <= '0;
            cfg_reg.shift_x <= '0;
            cfg_reg.shift_y <= '0;
            cfg_reg.shift_z <= '0;
            cfg_reg.len_x   <= 32'sd1 <<< FRAC_BITS;
            cfg_reg.len_y   <= '0;
            cfg_reg.sc_zx   <= '0;
            cfg_reg.sc_zy   <= '0;
            cfg_reg.sc_yx   <= '0;
            cfg_reg.sc_xy   <= '0;
            cfg_reg.ring_r  <= 32'sd1 <<< FRAC_BITS;
            cfg_reg.thick   <= 32'sd1 <<< (FRAC_BITS - 1);
        end else if (cfg_wr_en) begin
            case (stdist_pkg::reg_idx_t'(cfg_index))
                stdist_pkg::REG_MODE: begin
                    cfg_reg.mode <= cfg_data[8:0];
                end
                stdist_pkg::REG_SHIFT_X: begin
                    cfg_reg.shift_x <= cfg_data[31:0];
                end
                stdist_pkg::REG_SHIFT_Y: begin
                    cfg_reg.shift_y <= cfg_data[31:0];
                end
                stdist_pkg::REG_SHIFT_Z: begin
                    cfg_reg.shift_z <= cfg_data[31:0];
                end
                stdist_pkg::REG_LENGTHS: begin
                    cfg_reg.len_x <= cfg_data[63:32];
                    cfg_reg.len_y <= cfg_data[31:0];
                end
                stdist_pkg::REG_SCALES_A: begin
                    cfg_reg.sc_zx <= cfg_data[63:32];
                    cfg_reg.sc_zy <= cfg_data[31:0];
                end
                stdist_pkg::REG_SCALES_B: begin
                    cfg_reg.sc_yx <= cfg_data[63:32];
                    cfg_reg.sc_xy <= cfg_data[31:0];
                end
                stdist_pkg::REG_RADII: begin
                    cfg_reg.ring_r <= cfg_data[63:32];
                    cfg_reg.thick  <= cfg_data[31:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------- global pipe enable ----------------
    logic m_valid_reg;
    logic pipe_en;
    assign pipe_en = !m_valid_reg || m_ready;
    assign s_ready = pipe_en;

    // ---------------- front end ----------------
    logic               f_valid;
    stdist_pkg::carry_t f_carry;
    logic [63:0]        f_sum;

    stdist_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_x      (s_point_x),
        .in_y      (s_point_y),
        .in_z      (s_point_z),
        .in_prior  (s_prior_distance),
        .in_dsc    (s_derivative_scale),
        .out_valid (f_valid),
        .out_carry (f_carry),
        .out_sum   (f_sum)
    );

    // ---------------- first isqrt: planar ring length ----------------
    logic          sq1_v    [0:NS];
    logic [63:0]   sq1_n    [0:NS];
    logic [63:0]   sq1_r    [0:NS];
    logic [CW-1:0] sq1_side [0:NS];

    assign sq1_v[0]    = f_valid;
    assign sq1_n[0]    = f_sum;
    assign sq1_r[0]    = '0;
    assign sq1_side[0] = f_carry;

    for (genvar k = 0; k < NS; k++) begin : g_sq1
        stdist_sqrt_step #(.STEP(k), .SW(CW)) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (pipe_en),
            .in_valid  (sq1_v[k]),
            .in_n      (sq1_n[k]),
            .in_res    (sq1_r[k]),
            .in_side   (sq1_side[k]),
            .out_valid (sq1_v[k+1]),
            .out_n     (sq1_n[k+1]),
            .out_res   (sq1_r[k+1]),
            .out_side  (sq1_side[k+1])
        );
    end

    // ---------------- ring minus radius, clamped magnitude ----------------
    stdist_pkg::carry_t sq1_carry, rc_reg, qc1_reg, qc2_reg;
    logic signed [33:0] ring;
    logic        [33:0] ring_mag;
    logic        [31:0] ar_next, ar_reg, ar1_reg, ar2_reg;
    logic               rv_reg, qv1_reg, qv2_reg;
    logic        [63:0] rsq_reg, zsq_reg, rsum_reg;

    assign sq1_carry = sq1_side[NS];
    assign ring      = $signed({2'b00, sq1_r[NS][31:0]}) - 34'(cfg_reg.ring_r);
    assign ring_mag  = ring[33] ? (~ring + 34'd1) : ring;
    // |ring| saturates at 2^31
    assign ar_next   = (ring_mag > 34'h0_8000_0000) ? 32'h8000_0000 : ring_mag[31:0];

    logic [63:0] rsq, zsq;
    assign rsq = ar_reg * ar_reg;
    assign zsq = rc_reg.az * rc_reg.az;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rv_reg  <= 1'b0;
            qv1_reg <= 1'b0;
            qv2_reg <= 1'b0;
        end else if (pipe_en) begin
            rv_reg  <= sq1_v[NS];
            qv1_reg <= rv_reg;
            qv2_reg <= qv1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            rc_reg   <= sq1_carry;
            ar_reg   <= ar_next;
            qc1_reg  <= rc_reg;
            ar1_reg  <= ar_reg;
            rsq_reg  <= rsq;
            zsq_reg  <= zsq;
            qc2_reg  <= qc1_reg;
            ar2_reg  <= ar1_reg;
            rsum_reg <= rsq_reg + zsq_reg;
        end
    end

    // ---------------- second isqrt: round cross-section ----------------
    logic           sq2_v    [0:NS];
    logic [63:0]    sq2_n    [0:NS];
    logic [63:0]    sq2_r    [0:NS];
    logic [SW2-1:0] sq2_side [0:NS];

    assign sq2_v[0]    = qv2_reg;
    assign sq2_n[0]    = rsum_reg;
    assign sq2_r[0]    = '0;
    assign sq2_side[0] = {ar2_reg, qc2_reg};

    for (genvar k = 0; k < NS; k++) begin : g_sq2
        stdist_sqrt_step #(.STEP(k), .SW(SW2)) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (pipe_en),
            .in_valid  (sq2_v[k]),
            .in_n      (sq2_n[k]),
            .in_res    (sq2_r[k]),
            .in_side   (sq2_side[k]),
            .out_valid (sq2_v[k+1]),
            .out_n     (sq2_n[k+1]),
            .out_res   (sq2_r[k+1]),
            .out_side  (sq2_side[k+1])
        );
    end

    // ---------------- torus distance minus thickness ----------------
    stdist_pkg::carry_t t_carry, tc_reg;
    logic [31:0]        t_ar;
    logic [32:0]        tor;
    logic signed [33:0] diff;
    logic               neg_reg, tv_reg;
    logic [QW-1:0]      mag_reg;
    logic [31:0]        dvs_reg;

    assign t_carry = sq2_side[NS][CW-1:0];
    assign t_ar    = sq2_side[NS][SW2-1:CW];

    always_comb begin
        if (cfg_reg.mode[stdist_pkg::MB_SQUARE]) begin
            tor = (t_ar > t_carry.az) ? {1'b0, t_ar} : {1'b0, t_carry.az};
        end else begin
            tor = sq2_r[NS][32:0];
        end
    end

    assign diff = $signed({1'b0, tor}) - 34'(cfg_reg.thick);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tv_reg <= 1'b0;
        end else if (pipe_en) begin
            tv_reg <= sq2_v[NS];
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            tc_reg  <= t_carry;
            neg_reg <= diff[33];
            mag_reg <= diff[33] ? QW'(~diff + 34'd1) : QW'(diff);
            dvs_reg <= 32'(t_carry.dsc) + (32'd1 << FRAC_BITS);
        end
    end

    // ---------------- restoring divider, one quotient bit per stage ----------------
    logic           div_v    [0:QW];
    logic [RW-1:0]  div_rem  [0:QW];
    logic [QW-1:0]  div_q    [0:QW];
    logic [31:0]    div_dvs  [0:QW];
    logic [SWD-1:0] div_side [0:QW];

    assign div_v[0]    = tv_reg;
    assign div_rem[0]  = RW'(mag_reg) << FRAC_BITS;
    assign div_q[0]    = '0;
    assign div_dvs[0]  = dvs_reg;
    assign div_side[0] = {neg_reg, tc_reg};

    for (genvar k = 0; k < QW; k++) begin : g_div
        stdist_div_step #(.STEP(QW - 1 - k), .SW(SWD)) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (pipe_en),
            .in_valid  (div_v[k]),
            .in_rem    (div_rem[k]),
            .in_q      (div_q[k]),
            .in_dvs    (div_dvs[k]),
            .in_side   (div_side[k]),
            .out_valid (div_v[k+1]),
            .out_rem   (div_rem[k+1]),
            .out_q     (div_q[k+1]),
            .out_dvs   (div_dvs[k+1]),
            .out_side  (div_side[k+1])
        );
    end

    // ---------------- sign, saturate, min with prior ----------------
    stdist_pkg::carry_t d_carry;
    logic               d_neg;
    logic [QW-1:0]      qmag;
    logic signed [31:0] q_sat, res;

    assign d_carry = div_side[QW][CW-1:0];
    assign d_neg   = div_side[QW][CW];
    assign qmag    = div_q[QW];

    always_comb begin
        if (d_neg) begin
            q_sat = (qmag >= QW'(34'h0_8000_0000)) ? 32'sh8000_0000 : -$signed(qmag[31:0]);
        end else begin
            q_sat = (qmag > QW'(34'h0_7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(qmag[31:0]);
        end
        res = (d_carry.prior < q_sat) ? d_carry.prior : q_sat;
    end

    logic signed [31:0] mx_reg, my_reg, mz_reg, dist_reg, prior_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            m_valid_reg <= div_v[QW];
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            mx_reg        <= d_carry.mx;
            my_reg        <= d_carry.my;
            mz_reg        <= d_carry.mz;
            dist_reg      <= res;
            prior_out_reg <= d_carry.prior;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_moved_x      = mx_reg;
    assign m_moved_y      = my_reg;
    assign m_moved_z      = mz_reg;
    assign m_new_distance = dist_reg;

    // ---------------- checks ----------------
    `SD_ASSERT(a_div_rem_below_divisor, div_v[QW], div_rem[QW] < RW'(div_dvs[QW]))
    `SD_ASSERT(a_ring_clamped, rv_reg, ar_reg <= 32'h8000_0000)
    `SD_ASSERT(a_result_not_above_prior, m_valid_reg, dist_reg <= prior_out_reg)
    `SD_ASSERT_NEXT(a_held_result_keeps_prior, m_valid_reg && !m_ready, $stable(prior_out_reg))

endmodule

>>> src/stdist_front.sv
module stdist_front #(
    parameter int FRAC_BITS = stdist_pkg::FRAC_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  stdist_pkg::cfg_t          cfg,
    input  logic                      in_valid,
    input  logic signed [31:0]        in_x,
    input  logic signed [31:0]        in_y,
    input  logic signed [31:0]        in_z,
    input  logic signed [31:0]        in_prior,
    input  logic        [30:0]        in_dsc,
    output logic                      out_valid,
    output stdist_pkg::carry_t        out_carry,
    output logic        [63:0]        out_sum
);

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = 33'(a) + 33'(b);
        if (s[32] != s[31]) begin
            sat_add = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            sat_add = s[31:0];
        end
    endfunction

    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        abs32 = v[31] ? (~v + 32'd1) : v;
    endfunction

    // stage 1: shift, fold, swap, abs
    stdist_pkg::carry_t c1_next, c1_reg, c2_reg, c3_reg, c4_reg, c5_reg, c6_reg;
    logic [31:0] ax1_next, ay1_next, ax1_reg, ay1_reg, ax2_reg, ay2_reg, ax3_reg, ay3_reg;
    logic signed [31:0] mx, my, mz, wx, wz;

    always_comb begin
        mx = sat_add(in_x, cfg.shift_x);
        my = sat_add(in_y, cfg.shift_y);
        mz = sat_add(in_z, cfg.shift_z);
        if (cfg.mode[stdist_pkg::MB_FOLD_X] && !mx[31]) mx = -mx;
        if (cfg.mode[stdist_pkg::MB_FOLD_Y] && !my[31]) my = -my;
        if (cfg.mode[stdist_pkg::MB_FOLD_Z] && !mz[31]) mz = -mz;
        wx = cfg.mode[stdist_pkg::MB_SWAP] ? mz : mx;
        wz = cfg.mode[stdist_pkg::MB_SWAP] ? mx : mz;
        c1_next.mx    = mx;
        c1_next.my    = my;
        c1_next.mz    = mz;
        c1_next.prior = in_prior;
        c1_next.dsc   = in_dsc;
        c1_next.az    = abs32(wz);
        ax1_next      = abs32(wx);
        ay1_next      = abs32(my);
    end

    // stage 2: stretch products
    logic signed [64:0] m_zx, m_zy, m_yx, m_xy;
    logic signed [63:0] p_zx_reg, p_zy_reg, p_yx_reg, p_xy_reg;
    assign m_zx = $signed({1'b0, c1_reg.az}) * cfg.sc_zx;
    assign m_zy = $signed({1'b0, c1_reg.az}) * cfg.sc_zy;
    assign m_yx = $signed({1'b0, ay1_reg}) * cfg.sc_yx;
    assign m_xy = $signed({1'b0, ax1_reg}) * cfg.sc_xy;

    // stage 3: stretched half-lengths, floor shift
    logic signed [63:0] lx_next, ly_next, lx_reg, ly_reg;
    always_comb begin
        lx_next = 64'(cfg.len_x);
        ly_next = 64'(cfg.len_y);
        if (cfg.mode[stdist_pkg::MB_ZX]) lx_next = lx_next + (p_zx_reg >>> FRAC_BITS);
        if (cfg.mode[stdist_pkg::MB_YX]) lx_next = lx_next + (p_yx_reg >>> FRAC_BITS);
        if (cfg.mode[stdist_pkg::MB_ZY]) ly_next = ly_next + (p_zy_reg >>> FRAC_BITS);
        if (cfg.mode[stdist_pkg::MB_XY]) ly_next = ly_next + (p_xy_reg >>> FRAC_BITS);
    end

    // stage 4: planar excess, clamped to [0, 2^31]
    function automatic logic [31:0] excess(input logic [31:0] a, input logic signed [63:0] len);
        logic signed [63:0] d;
        d = $signed({32'd0, a}) - len;
        if (d[63]) begin
            excess = 32'd0;
        end else if (d > 64'sh8000_0000) begin
            excess = 32'h8000_0000;
        end else begin
            excess = d[31:0];
        end
    endfunction

    logic [31:0] ex_reg, ey_reg;
    // stage 5: squares, stage 6: sum
    logic [63:0] sqx, sqy, sqx_reg, sqy_reg, sum_reg;
    assign sqx = ex_reg * ex_reg;
    assign sqy = ey_reg * ey_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c1_reg   <= c1_next;
            ax1_reg  <= ax1_next;
            ay1_reg  <= ay1_next;
            c2_reg   <= c1_reg;
            ax2_reg  <= ax1_reg;
            ay2_reg  <= ay1_reg;
            p_zx_reg <= m_zx[63:0];
            p_zy_reg <= m_zy[63:0];
            p_yx_reg <= m_yx[63:0];
            p_xy_reg <= m_xy[63:0];
            c3_reg   <= c2_reg;
            ax3_reg  <= ax2_reg;
            ay3_reg  <= ay2_reg;
            lx_reg   <= lx_next;
            ly_reg   <= ly_next;
            c4_reg   <= c3_reg;
            ex_reg   <= excess(ay3_reg, ly_reg);
            ey_reg   <= excess(ax3_reg, lx_reg);
            c5_reg   <= c4_reg;
            sqx_reg  <= sqx;
            sqy_reg  <= sqy;
            c6_reg   <= c5_reg;
            sum_reg  <= sqx_reg + sqy_reg;
        end
    end

    assign out_valid = v6_reg;
    assign out_carry = c6_reg;
    assign out_sum   = sum_reg;

endmodule

>>> src/stdist_sqrt_step.sv
module stdist_sqrt_step #(
    parameter int STEP = 0,
    parameter int SW   = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [63:0]   in_n,
    input  logic [63:0]   in_res,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [63:0]   out_n,
    output logic [63:0]   out_res,
    output logic [SW-1:0] out_side
);

    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

    logic [63:0] trial, n_next, res_next, n_reg, res_reg;
    logic [SW-1:0] side_reg;
    logic valid_reg;

    always_comb begin
        trial = in_res + BIT;
        if (in_n >= trial) begin
            n_next   = in_n - trial;
            res_next = (in_res >> 1) + BIT;
        end else begin
            n_next   = in_n;
            res_next = in_res >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg    <= n_next;
            res_reg  <= res_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_n     = n_reg;
    assign out_res   = res_reg;
    assign out_side  = side_reg;

endmodule

>>> src/stdist_div_step.sv
module stdist_div_step #(
    parameter int STEP = 0,
    parameter int SW   = 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [stdist_pkg::DIV_RW-1:0] in_rem,
    input  logic [stdist_pkg::QW-1:0]     in_q,
    input  logic [31:0]                   in_dvs,
    input  logic [SW-1:0]                 in_side,
    output logic                          out_valid,
    output logic [stdist_pkg::DIV_RW-1:0] out_rem,
    output logic [stdist_pkg::QW-1:0]     out_q,
    output logic [31:0]                   out_dvs,
    output logic [SW-1:0]                 out_side
);

    logic [stdist_pkg::DIV_RW-1:0] sub, rem_next, rem_reg;
    logic [stdist_pkg::QW-1:0] q_next, q_reg;
    logic [31:0] dvs_reg;
    logic [SW-1:0] side_reg;
    logic valid_reg;

    assign sub = stdist_pkg::DIV_RW'(in_dvs) << STEP;

    always_comb begin
        rem_next = in_rem;
        q_next   = in_q;
        if (in_rem >= sub) begin
            rem_next     = in_rem - sub;
            q_next[STEP] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            q_reg    <= q_next;
            dvs_reg  <= in_dvs;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_q     = q_reg;
    assign out_dvs   = dvs_reg;
    assign out_side  = side_reg;

endmodule

>>> test/stretched_torus_distance_test.sv
module stretched_torus_distance_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  FB         = stdist_pkg::FRAC_BITS_DEF;
    localparam int  LIMIT      = 400000;  // cycles; slowest correct run is far below this
    localparam int  TAIL       = 160;     // pipe holds 109 stages
    localparam int  PHASES     = 10;
    localparam int  PER_PHASE  = 110;

    typedef struct {
        logic signed [31:0] mx;
        logic signed [31:0] my;
        logic signed [31:0] mz;
        logic signed [31:0] dval;
    } torus_result_t;

    // Holds a copy of the register file, predicts the result of each
    // accepted point and checks results in arrival order.
    class torus_board;
        bit [8:0]  mode;
        longint    sh_x, sh_y, sh_z, len_x, len_y;
        longint    k_zx, k_zy, k_yx, k_xy, ring_r, thick;
        torus_result_t pending_results[$];
        int        errors;

        function new();
            mode   = '0;
            sh_x   = 0; sh_y = 0; sh_z = 0;
            len_x  = 64'sd1 <<< FB; len_y = 0;
            k_zx   = 0; k_zy = 0; k_yx = 0; k_xy = 0;
            ring_r = 64'sd1 <<< FB;
            thick  = 64'sd1 <<< (FB - 1);
            errors = 0;
        endfunction

        static function longint s32(bit [31:0] v);
            return longint'($signed(v));
        endfunction

        static function longint clamp32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        static function longint mag(longint v);
            return v < 0 ? -v : v;
        endfunction

        // bitwise integer square root, rounds down
        static function longint unsigned root(longint unsigned n);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b = b >> 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        // planar excess, clipped to [0, 2^31]
        static function longint over(longint a, longint l);
            longint d;
            d = a - l;
            if (d < 0) return 0;
            if (d > 64'sd2147483648) return 64'sd2147483648;
            return d;
        endfunction

        function void write_reg(stdist_pkg::reg_idx_t idx, bit [63:0] v);
            case (idx)
                stdist_pkg::REG_MODE:     mode = v[8:0];
                stdist_pkg::REG_SHIFT_X:  sh_x = s32(v[31:0]);
                stdist_pkg::REG_SHIFT_Y:  sh_y = s32(v[31:0]);
                stdist_pkg::REG_SHIFT_Z:  sh_z = s32(v[31:0]);
                stdist_pkg::REG_LENGTHS:  begin
                    len_x = s32(v[63:32]); len_y = s32(v[31:0]);
                end
                stdist_pkg::REG_SCALES_A: begin
                    k_zx = s32(v[63:32]); k_zy = s32(v[31:0]);
                end
                stdist_pkg::REG_SCALES_B: begin
                    k_yx = s32(v[63:32]); k_xy = s32(v[31:0]);
                end
                stdist_pkg::REG_RADII:    begin
                    ring_r = s32(v[63:32]); thick = s32(v[31:0]);
                end
                default: ;
            endcase
        endfunction

        function void note_point(bit [31:0] x, bit [31:0] y, bit [31:0] z,
                                 bit [31:0] prior, bit [30:0] dscale);
            longint px, py, pz, wx, wz, ax, ay, az, lx, ly, ex, ey, ring, tor, num, q, res;
            torus_result_t e;
            px = clamp32(s32(x) + sh_x);
            py = clamp32(s32(y) + sh_y);
            pz = clamp32(s32(z) + sh_z);
            if (mode[stdist_pkg::MB_FOLD_X]) px = -mag(px);
            if (mode[stdist_pkg::MB_FOLD_Y]) py = -mag(py);
            if (mode[stdist_pkg::MB_FOLD_Z]) pz = -mag(pz);
            wx = px;
            wz = pz;
            if (mode[stdist_pkg::MB_SWAP]) begin
                wx = pz;
                wz = px;
            end
            ax = mag(wx);
            ay = mag(py);
            az = mag(wz);
            lx = len_x;
            ly = len_y;
            // arithmetic shift of a signed product is the floor
            if (mode[stdist_pkg::MB_ZX]) lx += (az * k_zx) >>> FB;
            if (mode[stdist_pkg::MB_ZY]) ly += (az * k_zy) >>> FB;
            if (mode[stdist_pkg::MB_YX]) lx += (ay * k_yx) >>> FB;
            if (mode[stdist_pkg::MB_XY]) ly += (ax * k_xy) >>> FB;
            ex = over(ay, ly);
            ey = over(ax, lx);
            ring = longint'(root(longint'(ex * ex) + longint'(ey * ey))) - ring_r;
            if (ring > 64'sd2147483648) ring = 64'sd2147483648;
            if (ring < -64'sd2147483648) ring = -64'sd2147483648;
            if (mode[stdist_pkg::MB_SQUARE])
                tor = mag(ring) > az ? mag(ring) : az;
            else
                tor = longint'(root(ring * ring + az * az));
            num = (tor - thick) * (64'sd1 <<< FB);
            q   = clamp32(num / (longint'(dscale) + (64'sd1 <<< FB)));  // truncates
            res = s32(prior) < q ? s32(prior) : q;
            e.mx   = px[31:0];
            e.my   = py[31:0];
            e.mz   = pz[31:0];
            e.dval = res[31:0];
            pending_results.push_back(e);
        endfunction

        function void check_result(torus_result_t got);
            torus_result_t e;
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected item: x=%0d y=%0d z=%0d d=%0d",
                             got.mx, got.my, got.mz, got.dval);
                return;
            end
            e = pending_results.pop_front();
            if (e.mx !== got.mx || e.my !== got.my || e.mz !== got.mz ||
                e.dval !== got.dval) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp x=%0d y=%0d z=%0d d=%0d got x=%0d y=%0d z=%0d d=%0d",
                             e.mx, e.my, e.mz, e.dval, got.mx, got.my, got.mz, got.dval);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT signals; the inputs are all known from time zero
    // ------------------------------------------------------------------
    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [63:0]        cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_point_x = '0;
    logic signed [31:0] s_point_y = '0;
    logic signed [31:0] s_point_z = '0;
    logic signed [31:0] s_prior_distance = '0;
    logic        [30:0] s_derivative_scale = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_moved_x;
    logic signed [31:0] m_moved_y;
    logic signed [31:0] m_moved_z;
    logic signed [31:0] m_new_distance;

    torus_board board = new();
    bit         calm = 1'b0;     // set for the last phase: no idling on either side
    int         stall_left = 0;
    int         cycles = 0;

    stretched_torus_distance dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_point_x         (s_point_x),
        .s_point_y         (s_point_y),
        .s_point_z         (s_point_z),
        .s_prior_distance  (s_prior_distance),
        .s_derivative_scale(s_derivative_scale),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_moved_x         (m_moved_x),
        .m_moved_y         (m_moved_y),
        .m_moved_z         (m_moved_z),
        .m_new_distance    (m_new_distance)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: ready drops in bursts unless calm.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 6);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Result monitor: sampled mid-cycle, where everything is settled;
    // the item moves at the next rising edge.
    always @(negedge aclk) begin
        torus_result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.mx   = m_moved_x;
            got.my   = m_moved_y;
            got.mz   = m_moved_z;
            got.dval = m_new_distance;
            board.check_result(got);
        end
    end

    // Corner values half the time, some small Q16.16 values, some anything.
    function automatic logic [31:0] pick32();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h8000_0000;
            3: return 32'hffff_ffff;
            4: return 32'h0001_0000;
            5, 6, 7: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] pick_scale();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 31'h7fff_ffff;
            2, 3: return 31'($urandom_range(0, 32'h0004_0000));
            default: return 31'($urandom);
        endcase
    endfunction

    task automatic write_reg(stdist_pkg::reg_idx_t idx, logic [63:0] v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        board.write_reg(idx, v);
    endtask

    task automatic end_writes();
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Every item gives a result, so an empty store means an idle pipe.
    task automatic drain();
        while (board.pending_results.size() > 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Offers one point and returns at the edge where it is taken.
    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              logic [31:0] prior, logic [30:0] dscale);
        bit taken;
        s_valid            <= 1'b1;
        s_point_x          <= x;
        s_point_y          <= y;
        s_point_z          <= z;
        s_prior_distance   <= prior;
        s_derivative_scale <= dscale;
        taken = 1'b0;
        while (!taken) begin
            @(negedge aclk);
            taken = s_ready;
            if (taken) board.note_point(x, y, z, prior, dscale);
            @(posedge aclk);
        end
    endtask

    // Sender gap, now and then unless calm; valid drops at the edge of acceptance.
    task automatic maybe_gap();
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
    endtask

    task automatic random_point();
        send_point(pick32(), pick32(), pick32(), pick32(), pick_scale());
        maybe_gap();
    endtask

    task automatic load_regs(int kind);
        logic [63:0] v;
        case (kind)
            0: begin   // all ones
                for (int i = 0; i < 8; i++) write_reg(stdist_pkg::reg_idx_t'(i), '1);
            end
            1: begin   // most negative shifts, zero lengths and scales
                write_reg(stdist_pkg::REG_MODE, 64'h0ff);
                write_reg(stdist_pkg::REG_SHIFT_X, 64'h8000_0000);
                write_reg(stdist_pkg::REG_SHIFT_Y, 64'h8000_0000);
                write_reg(stdist_pkg::REG_SHIFT_Z, 64'h8000_0000);
                write_reg(stdist_pkg::REG_LENGTHS, '0);
                write_reg(stdist_pkg::REG_SCALES_A, '0);
                write_reg(stdist_pkg::REG_SCALES_B, '0);
                write_reg(stdist_pkg::REG_RADII, '0);
            end
            2: begin   // largest positives; scales B and thickness most negative
                write_reg(stdist_pkg::REG_MODE, 64'h1f0);
                write_reg(stdist_pkg::REG_SHIFT_X, 64'h7fff_ffff);
                write_reg(stdist_pkg::REG_SHIFT_Y, 64'h7fff_ffff);
                write_reg(stdist_pkg::REG_SHIFT_Z, 64'h7fff_ffff);
                write_reg(stdist_pkg::REG_LENGTHS, 64'h7fff_ffff_7fff_ffff);
                write_reg(stdist_pkg::REG_SCALES_A, 64'h7fff_ffff_7fff_ffff);
                write_reg(stdist_pkg::REG_SCALES_B, 64'h8000_0000_8000_0000);
                write_reg(stdist_pkg::REG_RADII, 64'h7fff_ffff_8000_0000);
            end
            default: begin
                write_reg(stdist_pkg::REG_MODE, 64'($urandom_range(0, 511)));
                write_reg(stdist_pkg::REG_SHIFT_X, {32'h0, pick32()});
                write_reg(stdist_pkg::REG_SHIFT_Y, {32'h0, pick32()});
                write_reg(stdist_pkg::REG_SHIFT_Z, {32'h0, pick32()});
                write_reg(stdist_pkg::REG_LENGTHS, {pick32(), pick32()});
                // scales mostly near 1.0 so stretching stays in range
                v = {$urandom_range(0, 32'h0002_0000), $urandom_range(0, 32'h0002_0000)};
                write_reg(stdist_pkg::REG_SCALES_A,
                          $urandom_range(0, 3) == 0 ? {pick32(), pick32()} : v);
                v = {$urandom_range(0, 32'h0002_0000), $urandom_range(0, 32'h0002_0000)};
                write_reg(stdist_pkg::REG_SCALES_B,
                          $urandom_range(0, 3) == 0 ? {pick32(), pick32()} : v);
                write_reg(stdist_pkg::REG_RADII, {pick32(), pick32()});
            end
        endcase
        end_writes();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed items under reset defaults: zero point, field extremes,
        // largest derivative scale, prior winning and losing.
        send_point(32'h0, 32'h0, 32'h0, 32'h7fff_ffff, '0);
        send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, '0);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, '0);
        send_point(32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h8000_0000, 31'h7fff_ffff);
        send_point(32'h0001_8000, 32'h0, 32'h0, 32'h7fff_ffff, 31'h0001_0000);
        send_point(32'h0002_0000, 32'h0, 32'h0000_8000, 32'h0, '0);
        send_point(32'hffff_ffff, 32'h1, 32'hffff_ffff, 32'hffff_ffff, 31'h7fff_ffff);
        send_point(32'h0, 32'h0, 32'h7fff_ffff, 32'h7fff_ffff, 31'h1);
        s_valid <= 1'b0;
        drain();

        // All registers all ones (every mode bit set), then at their signed extremes.
        load_regs(0);
        send_point(32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 32'h7fff_ffff, '0);
        send_point(32'h0, 32'h0, 32'h0, 32'h7fff_ffff, '0);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '0);
        s_valid <= 1'b0;
        drain();
        load_regs(2);
        send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, '0);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 31'h7fff_ffff);
        send_point(32'h0, 32'h0, 32'h0, 32'h7fff_ffff, '0);
        s_valid <= 1'b0;
        drain();

        // Random phases, each under a fresh register setting.
        for (int p = 0; p < PHASES; p++) begin
            load_regs(p < 2 ? p : 3);
            calm = (p == PHASES - 1);
            for (int i = 0; i < PER_PHASE; i++) begin
                // once: hold off until the pipe is empty
                if (p == 3 && i == PER_PHASE / 2) begin
                    s_valid <= 1'b0;
                    while (board.pending_results.size() > 0) @(posedge aclk);
                end
                random_point();
            end
            s_valid <= 1'b0;
            drain();
        end

        repeat (TAIL) @(posedge aclk);
        if (board.errors == 0 && board.pending_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> stretched_torus_distance.f
+incdir+src
src/stdist_pkg.sv
src/stdist_front.sv
src/stdist_sqrt_step.sv
src/stdist_div_step.sv
src/stretched_torus_distance.sv
test/stretched_torus_distance_test.sv
